### rtl/core/tkrt_pkg.sv
// Shared constants, types and the key comparison of the ranked table.
package tkrt_pkg;

    localparam int CAPACITY = 64;
    localparam int AW       = $clog2(CAPACITY);
    localparam int CW       = 7;
    localparam int NUM_KEYS = 4;
    localparam int KEY_BITS = 32;
    localparam int ID_BITS  = 32;
    localparam int KWB      = 2;

    localparam logic [2:0] CMD_INSERT = 3'd0;
    localparam logic [2:0] CMD_UPDATE = 3'd1;
    localparam logic [2:0] CMD_REMOVE = 3'd2;
    localparam logic [2:0] CMD_RANK   = 3'd3;
    localparam logic [2:0] CMD_AT     = 3'd4;
    localparam logic [2:0] CMD_KEYS   = 3'd5;
    localparam logic [2:0] CMD_CLEAR  = 3'd6;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_KEY   = 3'd1;
    localparam logic [2:0] ST_ZERO_CAP  = 3'd2;
    localparam logic [2:0] ST_DUP       = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND = 3'd4;
    localparam logic [2:0] ST_RANK      = 3'd5;

    typedef struct packed {
        logic [ID_BITS-1:0]                 id;
        logic [NUM_KEYS-1:0][KEY_BITS-1:0]  key;
    } t_entry;

    typedef enum logic [12:0] {
        S_IDLE      = 13'b0000000000001,
        S_START     = 13'b0000000000010,
        S_FIND_RD   = 13'b0000000000100,
        S_FIND_CHK  = 13'b0000000001000,
        S_EVICT_RD  = 13'b0000000010000,
        S_EVICT_CHK = 13'b0000000100000,
        S_MOVE_RD   = 13'b0000001000000,
        S_MOVE_CHK  = 13'b0000010000000,
        S_SHIFT_RD  = 13'b0000100000000,
        S_SHIFT_CHK = 13'b0001000000000,
        S_READ_RD   = 13'b0010000000000,
        S_READ_CHK  = 13'b0100000000000,
        S_DONE      = 13'b1000000000000
    } t_state;

    function automatic logic beats(input t_entry a, input t_entry b, input logic [2:0] n);
        logic res;
        logic dec;
        res = 1'b0;
        dec = 1'b0;
        for (int w = 0; w < NUM_KEYS; w++) begin
            if (!dec && (w < int'(n))) begin
                if (a.key[w] > b.key[w]) begin
                    res = 1'b1;
                    dec = 1'b1;
                end else if (a.key[w] < b.key[w]) begin
                    dec = 1'b1;
                end
            end
        end
        return res;
    endfunction

endpackage

### rtl/core/top_k_ranked_table.sv
// Top level of the ranked table: command sequencer around one entry memory.
//
// Commands arrive on the i_valid / o_ready channel, one transfer per command, and
// every command gives exactly one result transfer on o_valid / i_ready.
// The capacity limit is written through i_cfg_valid / i_cfg_data; o_cfg_ready
// is always high and the write should only be made while the block is idle.
// The table lives in a 64-entry memory with a registered read port, and
// every step that touches it is a read state, which issues the read,
// followed by a check state that uses the data and, when entries move, writes back.
// A clear or a rejected command goes from the start state straight to the
// done state, and a query by rank adds one read of the memory; a search
// by id reads the entries from the top one by one, and an insert, update
// or remove then moves the entry slot by slot or shifts the entries below it.
// Only one command is in progress at a time; o_ready rises again when the
// result has been placed in the output register.
// Reset empties the table and sets the capacity limit to 64.
// When the receiver stalls, the result stays in the output register and a
// further command may be taken, but its result waits until the register frees.
module top_k_ranked_table
    import tkrt_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [2:0]          i_cmd,
    input  logic [31:0]         i_obj_id,
    input  logic [31:0]         i_key_0,
    input  logic [31:0]         i_key_1,
    input  logic [31:0]         i_key_2,
    input  logic [31:0]         i_key_3,
    input  logic [2:0]          i_key_index,
    input  logic [6:0]          i_rank_in,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [6:0]          i_cfg_data,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [2:0]          o_status,
    output logic                o_kept,
    output logic [6:0]          o_rank_out,
    output logic [31:0]         o_id_out,
    output logic [31:0]         o_key_out_0,
    output logic [31:0]         o_key_out_1,
    output logic [31:0]         o_key_out_2,
    output logic [31:0]         o_key_out_3
);

    t_entry mem [CAPACITY];
    t_entry r_rdata;

    t_state r_state, n_state;
    logic [2:0]    r_cmd;
    logic [2:0]    r_ki;
    logic [6:0]    r_rank;
    t_entry        r_ent, n_ent;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [2:0]    r_kwu, n_kwu;
    logic [CW-1:0] r_cap;
    logic [CW-1:0] r_p, n_p;
    logic          r_down, n_down;

    logic [2:0]          r_st, n_st;
    logic                r_kp, n_kp;
    logic [6:0]          r_rk, n_rk;
    logic [31:0]         r_io, n_io;
    logic [3:0][31:0]    r_ko, n_ko;

    logic                r_ovalid;
    logic [2:0]          r_o_status;
    logic                r_o_kept;
    logic [6:0]          r_o_rank;
    logic [31:0]         r_o_id;
    logic [3:0][31:0]    r_o_key;

    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    t_entry        wr_data;

    logic [CW-1:0] cap_eff;
    logic          ki_bad;
    logic [KWB-1:0] upd_w;
    logic          load_out;

    assign cap_eff = (r_cap > CW'(CAPACITY)) ? CW'(CAPACITY) : r_cap;
    assign ki_bad  = (r_ki == 3'd0) || (r_ki > 3'(NUM_KEYS));
    assign upd_w   = KWB'(r_ki - 3'd1);
    assign load_out = (r_state == S_DONE) && (!r_ovalid || i_ready);

    assign o_ready     = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_state = r_state;
        n_ent   = r_ent;
        n_cnt   = r_cnt;
        n_kwu   = r_kwu;
        n_p     = r_p;
        n_down  = r_down;
        n_st    = r_st;
        n_kp    = r_kp;
        n_rk    = r_rk;
        n_io    = r_io;
        n_ko    = r_ko;
        rd_en   = 1'b0;
        rd_addr = r_p[AW-1:0];
        wr_en   = 1'b0;
        wr_addr = r_p[AW-1:0];
        wr_data = r_ent;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_START;
                end
            end
            S_START: begin
                n_st = ST_OK;
                n_kp = 1'b0;
                n_rk = '0;
                n_io = '0;
                n_ko = '0;
                n_p  = '0;
                n_state = S_DONE;
                case (r_cmd)
                    CMD_INSERT: begin
                        if (ki_bad) begin
                            n_st = ST_BAD_KEY;
                        end else if (cap_eff == '0) begin
                            n_st = ST_ZERO_CAP;
                        end else begin
                            if (r_ki > r_kwu) begin
                                n_kwu = r_ki;
                            end
                            n_state = S_FIND_RD;
                        end
                    end
                    CMD_UPDATE: begin
                        if (ki_bad) begin
                            n_st = ST_BAD_KEY;
                        end else begin
                            n_state = S_FIND_RD;
                        end
                    end
                    CMD_REMOVE, CMD_RANK, CMD_KEYS: begin
                        n_state = S_FIND_RD;
                    end
                    CMD_AT: begin
                        if (r_rank == 7'd0 || r_rank > r_cnt) begin
                            n_st = ST_RANK;
                        end else begin
                            n_p = CW'(r_rank - 7'd1);
                            n_state = S_READ_RD;
                        end
                    end
                    CMD_CLEAR: begin
                        n_cnt = '0;
                        n_kwu = '0;
                    end
                    default: begin
                    end
                endcase
            end
            S_FIND_RD: begin
                if (r_p == r_cnt) begin
                    n_state = S_DONE;
                    if (r_cmd == CMD_INSERT) begin
                        if (r_cnt >= cap_eff) begin
                            n_p = r_cnt - 7'd1;
                            n_state = S_EVICT_RD;
                        end else begin
                            n_cnt  = r_cnt + 7'd1;
                            n_kp   = 1'b1;
                            n_down = 1'b0;
                            n_state = S_MOVE_RD;
                        end
                    end else begin
                        n_st = ST_NOT_FOUND;
                    end
                end else begin
                    rd_en = 1'b1;
                    n_state = S_FIND_CHK;
                end
            end
            S_FIND_CHK: begin
                if (r_rdata.id == r_ent.id) begin
                    n_state = S_DONE;
                    case (r_cmd)
                        CMD_INSERT: begin
                            n_st = ST_DUP;
                        end
                        CMD_UPDATE: begin
                            if (r_rdata.key[upd_w] != r_ent.key[0]) begin
                                n_ent = r_rdata;
                                n_ent.key[upd_w] = r_ent.key[0];
                                if (r_ki > r_kwu) begin
                                    n_kwu = r_ki;
                                end
                                n_down = (r_rdata.key[upd_w] > r_ent.key[0]);
                                n_state = S_MOVE_RD;
                            end
                        end
                        CMD_REMOVE: begin
                            n_state = S_SHIFT_RD;
                        end
                        CMD_RANK: begin
                            n_rk = r_p + 7'd1;
                        end
                        default: begin
                            n_ko = r_rdata.key;
                        end
                    endcase
                end else begin
                    n_p = r_p + 7'd1;
                    n_state = S_FIND_RD;
                end
            end
            S_EVICT_RD: begin
                rd_en = 1'b1;
                n_state = S_EVICT_CHK;
            end
            S_EVICT_CHK: begin
                if (beats(r_ent, r_rdata, r_kwu)) begin
                    n_kp = 1'b1;
                    n_down = 1'b0;
                    n_state = S_MOVE_RD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_MOVE_RD: begin
                if (r_down) begin
                    if (r_p + 7'd1 >= r_cnt) begin
                        wr_en = 1'b1;
                        n_state = S_DONE;
                    end else begin
                        rd_en = 1'b1;
                        rd_addr = AW'(r_p + 7'd1);
                        n_state = S_MOVE_CHK;
                    end
                end else begin
                    if (r_p == '0) begin
                        wr_en = 1'b1;
                        n_state = S_DONE;
                    end else begin
                        rd_en = 1'b1;
                        rd_addr = AW'(r_p - 7'd1);
                        n_state = S_MOVE_CHK;
                    end
                end
            end
            S_MOVE_CHK: begin
                if (r_down ? beats(r_rdata, r_ent, r_kwu)
                           : beats(r_ent, r_rdata, r_kwu)) begin
                    wr_en   = 1'b1;
                    wr_data = r_rdata;
                    n_p     = r_down ? r_p + 7'd1 : r_p - 7'd1;
                    n_state = S_MOVE_RD;
                end else begin
                    wr_en   = 1'b1;
                    n_state = S_DONE;
                end
            end
            S_SHIFT_RD: begin
                if (r_p + 7'd1 >= r_cnt) begin
                    n_cnt = r_cnt - 7'd1;
                    n_state = S_DONE;
                end else begin
                    rd_en = 1'b1;
                    rd_addr = AW'(r_p + 7'd1);
                    n_state = S_SHIFT_CHK;
                end
            end
            S_SHIFT_CHK: begin
                wr_en   = 1'b1;
                wr_data = r_rdata;
                n_p     = r_p + 7'd1;
                n_state = S_SHIFT_RD;
            end
            S_READ_RD: begin
                rd_en = 1'b1;
                n_state = S_READ_CHK;
            end
            S_READ_CHK: begin
                n_io = r_rdata.id;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
        end
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_kwu    <= '0;
            r_cap    <= CW'(CAPACITY);
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_kwu   <= n_kwu;
            if (i_cfg_valid) begin
                r_cap <= i_cfg_data;
            end
            if (load_out) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_p    <= n_p;
        r_down <= n_down;
        r_st   <= n_st;
        r_kp   <= n_kp;
        r_rk   <= n_rk;
        r_io   <= n_io;
        r_ko   <= n_ko;
        if (r_state == S_IDLE && i_valid) begin
            r_cmd  <= i_cmd;
            r_ki   <= i_key_index;
            r_rank <= i_rank_in;
            r_ent  <= '{id: i_obj_id, key: {i_key_3, i_key_2, i_key_1, i_key_0}};
        end else begin
            r_ent  <= n_ent;
        end
        if (load_out) begin
            r_o_status <= r_st;
            r_o_kept   <= r_kp;
            r_o_rank   <= r_rk;
            r_o_id     <= r_io;
            r_o_key    <= r_ko;
        end
    end

    assign o_valid     = r_ovalid;
    assign o_status    = r_o_status;
    assign o_kept      = r_o_kept;
    assign o_rank_out  = r_o_rank;
    assign o_id_out    = r_o_id;
    assign o_key_out_0 = r_o_key[0];
    assign o_key_out_1 = r_o_key[1];
    assign o_key_out_2 = r_o_key[2];
    assign o_key_out_3 = r_o_key[3];

endmodule

### rtl/core/tkrt_checker.sv
// Port-level checks on the ranked table, bound to the top level.
module tkrt_checker
    import tkrt_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [2:0]  o_status,
    input logic        o_kept,
    input logic [6:0]  o_rank_out,
    input logic [31:0] o_id_out
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_status))
        else $error("result dropped while stalled");

    a_kept_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kept |-> o_status == ST_OK)
        else $error("kept with a failing status");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_OK |-> o_rank_out == 7'd0 && o_id_out == 32'd0)
        else $error("answer given with a failing status");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("second command taken while one is in progress");

    a_rank_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_rank_out <= 7'(CAPACITY))
        else $error("rank beyond capacity");

endmodule

bind top_k_ranked_table tkrt_checker u_tkrt_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_valid    (i_valid),
    .o_ready    (o_ready),
    .o_valid    (o_valid),
    .i_ready    (i_ready),
    .o_status   (o_status),
    .o_kept     (o_kept),
    .o_rank_out (o_rank_out),
    .o_id_out   (o_id_out)
);

### tb/tb.sv
// Self-checking testbench for the ranked table, with its own model of the table.
`timescale 1ns / 1ps
module tb;
    import tkrt_pkg::*;

    localparam logic [2:0] CMD_SPARE = 3'd7;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [2:0]  i_cmd = '0;
    logic [31:0] i_obj_id = '0;
    logic [31:0] i_key_0 = '0, i_key_1 = '0, i_key_2 = '0, i_key_3 = '0;
    logic [2:0]  i_key_index = '0;
    logic [6:0]  i_rank_in = '0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [6:0]  i_cfg_data = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [2:0]  o_status;
    logic        o_kept;
    logic [6:0]  o_rank_out;
    logic [31:0] o_id_out, o_key_out_0, o_key_out_1, o_key_out_2, o_key_out_3;

    top_k_ranked_table dut (.*);

    always #2 i_clk = ~i_clk;

    typedef struct packed {
        logic [2:0]  status;
        logic        kept;
        logic [6:0]  rank;
        logic [31:0] id;
        logic [3:0][31:0] keys;
    } t_answer;

    logic [31:0]      board_id [CAPACITY];
    logic [3:0][31:0] board_key [CAPACITY];
    int               board_count;
    int               words_used;
    int               cap_reg;
    t_answer          answers_due[$];
    int               mismatches;
    int               results_seen;
    int               quiet_cycles;
    int               sent_count;
    bit               calm;
    int               recent_ids[$];
    int               stall_left = 0;

    function automatic int key_order(input logic [3:0][31:0] a, input logic [3:0][31:0] b);
        for (int w = 0; w < NUM_KEYS; w++) begin
            if (w < words_used) begin
                if (a[w] > b[w]) return 1;
                if (a[w] < b[w]) return -1;
            end
        end
        return 0;
    endfunction

    function automatic void swap_entries(input int a, input int b);
        logic [31:0]      t;
        logic [3:0][31:0] k;
        t = board_id[a]; board_id[a] = board_id[b]; board_id[b] = t;
        k = board_key[a]; board_key[a] = board_key[b]; board_key[b] = k;
    endfunction

    function automatic int locate(input logic [31:0] id);
        int i;
        for (i = 0; i < board_count; i++)
            if (board_id[i] == id) break;
        return i;
    endfunction

    function automatic void delete_entry(input int p);
        for (int i = p; i + 1 < board_count; i++) begin
            board_id[i] = board_id[i + 1];
            board_key[i] = board_key[i + 1];
        end
        if (board_count > 0) board_count--;
    endfunction

    function automatic t_answer apply_command(input logic [2:0] cmd, input logic [31:0] id,
                                              input logic [3:0][31:0] k,
                                              input logic [2:0] ki, input logic [6:0] rk);
        t_answer          a;
        int               cap, p, w;
        logic [31:0]      old;
        a = '0;
        cap = cap_reg < CAPACITY ? cap_reg : CAPACITY;
        case (cmd)
            CMD_INSERT: begin
                if (ki < 1 || ki > NUM_KEYS) a.status = ST_BAD_KEY;
                else if (cap == 0) a.status = ST_ZERO_CAP;
                else begin
                    if (ki > words_used) words_used = ki;
                    if (locate(id) < board_count) a.status = ST_DUP;
                    else if (board_count >= cap && key_order(k, board_key[board_count-1]) <= 0)
                        a.kept = 1'b0;
                    else begin
                        if (board_count >= cap) delete_entry(board_count - 1);
                        p = board_count;
                        board_id[p] = id;
                        board_key[p] = k;
                        board_count++;
                        while (p > 0 && key_order(board_key[p], board_key[p-1]) > 0) begin
                            swap_entries(p, p - 1);
                            p--;
                        end
                        a.kept = 1'b1;
                    end
                end
            end
            CMD_UPDATE: begin
                p = locate(id);
                if (ki < 1 || ki > NUM_KEYS) a.status = ST_BAD_KEY;
                else if (p >= board_count) a.status = ST_NOT_FOUND;
                else begin
                    w = ki - 1;
                    old = board_key[p][w];
                    if (old != k[0]) begin
                        board_key[p][w] = k[0];
                        if (ki > words_used) words_used = ki;
                        if (old > k[0]) begin
                            while (p + 1 < board_count &&
                                   key_order(board_key[p], board_key[p+1]) < 0) begin
                                swap_entries(p, p + 1);
                                p++;
                            end
                        end else begin
                            while (p > 0 && key_order(board_key[p], board_key[p-1]) > 0) begin
                                swap_entries(p, p - 1);
                                p--;
                            end
                        end
                    end
                end
            end
            CMD_REMOVE: begin
                p = locate(id);
                if (p >= board_count) a.status = ST_NOT_FOUND;
                else delete_entry(p);
            end
            CMD_RANK: begin
                p = locate(id);
                if (p >= board_count) a.status = ST_NOT_FOUND;
                else a.rank = 7'(p + 1);
            end
            CMD_AT: begin
                if (rk < 1 || rk > board_count) a.status = ST_RANK;
                else a.id = board_id[rk - 1];
            end
            CMD_KEYS: begin
                p = locate(id);
                if (p >= board_count) a.status = ST_NOT_FOUND;
                else a.keys = board_key[p];
            end
            CMD_CLEAR: begin
                board_count = 0;
                words_used = 0;
            end
            default: ;
        endcase
        return a;
    endfunction

    task automatic gap();
        if (!calm && $urandom_range(3) == 0) repeat ($urandom_range(1, 19)) @(posedge i_clk);
    endtask

    task automatic send_command(input logic [2:0] cmd, input logic [31:0] id,
                                input logic [3:0][31:0] k, input logic [2:0] ki,
                                input logic [6:0] rk);
        gap();
        i_valid <= 1'b1;
        i_cmd <= cmd; i_obj_id <= id;
        i_key_0 <= k[0]; i_key_1 <= k[1]; i_key_2 <= k[2]; i_key_3 <= k[3];
        i_key_index <= ki; i_rank_in <= rk;
        do @(posedge i_clk); while (!o_ready);
        answers_due.insert(answers_due.size(), apply_command(cmd, id, k, ki, rk));
        sent_count++;
        if (cmd == CMD_INSERT) begin
            recent_ids.insert(recent_ids.size(), int'(id));
            if (recent_ids.size() > 48) void'(recent_ids.pop_front());
        end
        i_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        while (answers_due.size() != 0) @(posedge i_clk);
        repeat (600) @(posedge i_clk);
    endtask

    task automatic set_capacity(input logic [6:0] v);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        cap_reg = v;
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [3:0][31:0] random_keys(input bit narrow);
        logic [3:0][31:0] k;
        for (int w = 0; w < 4; w++)
            k[w] = narrow ? 32'($urandom_range(3)) : $urandom;
        return k;
    endfunction

    function automatic logic [31:0] pick_id();
        if (recent_ids.size() != 0 && $urandom_range(3) != 0)
            return 32'(recent_ids[$urandom_range(recent_ids.size() - 1)]);
        return $urandom_range(4) == 0 ? $urandom : 32'($urandom_range(40));
    endfunction

    always @(posedge i_clk) begin
        if (calm) begin
            i_ready <= 1'b1;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            i_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(5) == 0) begin
            i_ready <= 1'b0;
            stall_left <= $urandom_range(18);
        end else begin
            i_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            t_answer want, got;
            got = {o_status, o_kept, o_rank_out, o_id_out,
                   o_key_out_3, o_key_out_2, o_key_out_1, o_key_out_0};
            results_seen++;
            if (answers_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("result with nothing expected: %h", got);
            end else begin
                want = answers_due.pop_front();
                if (want != got) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("result %0d: expected st=%0d kept=%0d rank=%0d id=%h keys=%h,",
                                 results_seen, want.status, want.kept, want.rank, want.id,
                                 want.keys);
                        $display("    got st=%0d kept=%0d rank=%0d id=%h keys=%h",
                                 got.status, got.kept, got.rank, got.id, got.keys);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 20000) begin
            $display("top_k_ranked_table: mismatch");
            $finish;
        end
    end

    task automatic test_directed();
        logic [3:0][31:0] ones;
        ones = {4{32'hFFFF_FFFF}};
        send_command(CMD_INSERT, 32'h1, ones, 3'd0, 7'd0);
        send_command(CMD_INSERT, 32'h1, ones, 3'd5, 7'd0);
        send_command(CMD_INSERT, 32'hFFFF_FFFF, ones, 3'd4, 7'd0);
        send_command(CMD_INSERT, 32'h0, '0, 3'd1, 7'd0);
        send_command(CMD_INSERT, 32'h5, {32'd0, 32'd0, 32'd0, 32'd0}, 3'd2, 7'd0);
        send_command(CMD_INSERT, 32'h5, ones, 3'd2, 7'd0);
        send_command(CMD_UPDATE, 32'h5, {96'd0, 32'd7}, 3'd1, 7'd0);
        send_command(CMD_UPDATE, 32'h5, {96'd0, 32'd7}, 3'd1, 7'd0);
        send_command(CMD_UPDATE, 32'h0, {96'd0, 32'hFFFF_FFFF}, 3'd4, 7'd0);
        send_command(CMD_UPDATE, 32'h9, '0, 3'd1, 7'd0);
        send_command(CMD_UPDATE, 32'h5, '0, 3'd7, 7'd0);
        send_command(CMD_RANK, 32'h0, '0, 3'd0, 7'd0);
        send_command(CMD_RANK, 32'h77, '0, 3'd0, 7'd0);
        send_command(CMD_AT, 32'h0, '0, 3'd0, 7'd0);
        send_command(CMD_AT, 32'h0, '0, 3'd0, 7'd1);
        send_command(CMD_AT, 32'h0, '0, 3'd0, 7'd127);
        send_command(CMD_KEYS, 32'hFFFF_FFFF, '0, 3'd0, 7'd0);
        send_command(CMD_KEYS, 32'h42, '0, 3'd0, 7'd0);
        send_command(CMD_REMOVE, 32'h5, '0, 3'd0, 7'd0);
        send_command(CMD_REMOVE, 32'h5, '0, 3'd0, 7'd0);
        send_command(CMD_SPARE, 32'h1, ones, 3'd1, 7'd1);
        send_command(CMD_CLEAR, 32'h0, '0, 3'd0, 7'd0);
    endtask

    task automatic test_limits();
        set_capacity(7'd0);
        send_command(CMD_INSERT, 32'h3, '0, 3'd1, 7'd0);
        set_capacity(7'd2);
        for (int i = 0; i < 6; i++)
            send_command(CMD_INSERT, 32'(100 + i), {96'd0, 32'(i % 3)}, 3'd1, 7'd0);
        set_capacity(7'd1);
        send_command(CMD_INSERT, 32'd200, {96'd0, 32'd9}, 3'd1, 7'd0);
        send_command(CMD_AT, 32'd0, '0, 3'd0, 7'd2);
        set_capacity(7'd127);
        send_command(CMD_CLEAR, 32'd0, '0, 3'd0, 7'd0);
    endtask

    task automatic test_random(input int count, input int cap_max);
        logic [2:0] cmd;
        logic [2:0] ki;
        bit         narrow;
        for (int n = 0; n < count; n++) begin
            narrow = $urandom_range(3) != 0;
            case ($urandom_range(19))
                0, 1, 2, 3, 4, 5, 6: cmd = CMD_INSERT;
                7, 8, 9:             cmd = CMD_UPDATE;
                10, 11:              cmd = CMD_REMOVE;
                12, 13:              cmd = CMD_RANK;
                14, 15:              cmd = CMD_AT;
                16, 17:              cmd = CMD_KEYS;
                18:                  cmd = ($urandom_range(9) == 0) ? CMD_CLEAR : CMD_RANK;
                default:             cmd = $urandom_range(15) == 0 ? CMD_SPARE : CMD_INSERT;
            endcase
            ki = $urandom_range(9) == 0 ? 3'($urandom) : 3'($urandom_range(1, 4));
            send_command(cmd, pick_id(), random_keys(narrow), ki,
                         $urandom_range(7) == 0 ? 7'($urandom) :
                                                  7'($urandom_range(cap_max + 1)));
        end
    endtask

    initial begin
        board_count = 0; words_used = 0; cap_reg = 64;
        mismatches = 0; results_seen = 0; quiet_cycles = 0; sent_count = 0; calm = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_limits();
        set_capacity(7'd64);
        test_random(500, 64);
        set_capacity(7'd5);
        test_random(300, 5);
        set_capacity(7'd65);
        test_random(250, 64);
        calm = 1;
        set_capacity(7'd12);
        test_random(200, 12);
        drain();
        $display("Covered %0d commands and %0d results over capacity settings 0 to 127,",
                 sent_count, results_seen);
        $display("including full-table eviction, ties, updates in both directions and clears.");
        if (mismatches == 0) $display("top_k_ranked_table: match");
        else $display("top_k_ranked_table: mismatch");
        $finish;
    end
endmodule
